// ----- rtl/core/estsc_pkg.sv -----
// estsc_pkg: shared types and constants of the ema swing trend score core
// no dependencies
package estsc_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam logic [15:0] GAIN_RST = 16'd6242;
    localparam logic [16:0] BULL_RST = 17'd39322;
    localparam logic [16:0] BEAR_RST = 17'd26214;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    localparam logic [1:0] CFG_GAIN = 2'd0;
    localparam logic [1:0] CFG_BULL = 2'd1;
    localparam logic [1:0] CFG_BEAR = 2'd2;

    localparam logic [1:0] CLS_BULL     = 2'd0;
    localparam logic [1:0] CLS_BEAR     = 2'd1;
    localparam logic [1:0] CLS_UNSTABLE = 2'd2;

    typedef struct packed {
        logic [31:0] high_price;
        logic [31:0] low_price;
        logic [6:0]  window_len;
        logic        last_candle;
    } candle_t;

    typedef struct packed {
        logic [16:0] trend_score_q16;
        logic [1:0]  trend_class;
        logic [31:0] high_swing_count;
        logic [31:0] low_swing_count;
    } score_t;

endpackage

// ----- rtl/core/estsc_div.sv -----
// estsc_div: radix-2 restoring divider, one quotient bit per cycle
// depends on estsc_pkg
module estsc_div
    import estsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [16:0] quo
);
    logic [47:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    assign quo  = n_reg[16:0];
    assign done = busy_reg && (cnt_reg == 6'd0);
    assign trial = {r_reg, n_reg[47]};

    always_comb begin
        n_next = n_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            n_next = num;
            r_next = 32'd0;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg != 6'd0) begin
            if (trial >= {1'b0, den}) begin
                r_next = 32'(trial - {1'b0, den});
                n_next = {n_reg[46:0], 1'b1};
            end else begin
                r_next = trial[31:0];
                n_next = {n_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        n_reg <= n_next;
        r_reg <= r_next;
    end
endmodule

// ----- rtl/core/ema_swing_trend_score_core.sv -----
// ema_swing_trend_score_core: top level of the candle trend scorer
// depends on estsc_pkg and estsc_div
//
// usage: candle words enter on s_ (valid/ready); a score word leaves on m_
// only for a candle with last_candle set. config writes on cfg_ (index 0
// gain, 1 bull threshold, 2 bear threshold) are taken while idle.
// each candle runs through a sequencer sharing one 48x16 multiplier built
// from two 24x16 partial products: high series then low series, each
// through two products, a settle step and a swing update; ready comes back
// only when both series are done. on the last candle each series gets a
// prep step, a popcount sweep over the WINDOW_MAX window bits (skipped for
// window 0), a division start and a serial division; after both series the
// score word is registered and offered on m_.
// ready stays low while a candle is in work or a result waits,
// so a stalled receiver holds the block with its word unchanged.
// reset clears all series state and loads the default config registers;
// after a result the series state is cleared again.
module ema_swing_trend_score_core
    import estsc_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  candle_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output score_t      m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    localparam int WB = $clog2(WINDOW_MAX + 1);
    localparam int IB = $clog2(WINDOW_MAX);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MUL0  = 11'b00000000010,
        ST_MUL1  = 11'b00000000100,
        ST_UPD   = 11'b00000001000,
        ST_SWING = 11'b00000010000,
        ST_PREP  = 11'b00000100000,
        ST_POP   = 11'b00001000000,
        ST_DSTRT = 11'b00010000000,
        ST_DWAIT = 11'b00100000000,
        ST_FIN   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] gain_reg;
    logic [16:0] bull_reg, bear_reg;
    candle_t in_reg;
    logic [1:0] seen_reg;
    logic [47:0] now_reg [2];
    logic [47:0] back_reg [2];
    logic [47:0] lsw_reg [2];
    logic [31:0] sw_reg [2];
    logic [31:0] ri_reg [2];
    logic [WINDOW_MAX-1:0] bits_reg [2];
    logic sel_reg;
    logic [47:0] diff_reg, nxt_reg;
    logic neg_reg;
    logic [39:0] plo_reg;
    logic [16:0] f_reg [2];
    logic [31:0] comps_reg;
    logic [31:0] up_reg;
    logic [IB:0] pi_reg;
    score_t out_reg;

    logic [47:0] price_q16, cur;
    logic [47:0] d_cur, d_price;
    logic [23:0] mul_a;
    logic [39:0] mul_p;
    logic [63:0] prod;
    logic [47:0] step, ema_new;
    logic [WB-1:0] win_c;
    logic [31:0] cnt_c, sw_m1;
    logic [31:0] comps_c;
    logic div_start, div_done;
    logic [16:0] div_q;
    logic [17:0] fsum;
    logic [16:0] score;

    assign cur = now_reg[sel_reg];
    assign price_q16 = {8'd0, (sel_reg ? in_reg.low_price : in_reg.high_price), 8'd0};
    assign mul_a = (state_reg == ST_MUL0) ? diff_reg[23:0] : diff_reg[47:24];
    assign mul_p = mul_a * gain_reg;
    assign prod = {mul_p, 24'd0} + {24'd0, plo_reg};
    assign step = neg_reg ? 48'((prod + 64'd65535) >> 16) : 48'(prod >> 16);
    assign ema_new = neg_reg ? cur - step : cur + step;

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data = out_reg;

    always_comb begin
        if (in_reg.window_len > 7'(WINDOW_MAX)) win_c = WB'(WINDOW_MAX);
        else win_c = WB'(in_reg.window_len);
        sw_m1 = (sw_reg[sel_reg] == 32'd0) ? 32'd0 : sw_reg[sel_reg] - 32'd1;
        cnt_c = (sw_reg[sel_reg] < 32'(win_c)) ? sw_reg[sel_reg] : 32'(win_c);
        comps_c = (cnt_c == 32'd0) ? 32'd0 : cnt_c - 32'd1;
    end

    assign div_start = (state_reg == ST_DSTRT);

    estsc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({up_reg, 16'd0}), .den(comps_reg), .done(div_done), .quo(div_q)
    );

    assign fsum = {1'b0, f_reg[0]} + {1'b0, f_reg[1]};
    assign score = fsum[17:1];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MUL0;
            ST_MUL0:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_SWING;
            ST_SWING: begin
                if (!sel_reg) state_next = ST_MUL0;
                else if (in_reg.last_candle) state_next = ST_PREP;
                else state_next = ST_IDLE;
            end
            ST_PREP: begin
                if (win_c == '0) state_next = ST_DSTRT;
                else state_next = ST_POP;
            end
            ST_POP:   if (pi_reg == (IB+1)'(WINDOW_MAX - 1)) state_next = ST_DSTRT;
            ST_DSTRT: state_next = ST_DWAIT;
            ST_DWAIT: if (div_done) state_next = sel_reg ? ST_FIN : ST_PREP;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gain_reg <= GAIN_RST;
            bull_reg <= BULL_RST;
            bear_reg <= BEAR_RST;
            seen_reg <= 2'd0;
            sel_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                now_reg[i] <= '0;
                back_reg[i] <= '0;
                lsw_reg[i] <= '0;
                sw_reg[i] <= '0;
                ri_reg[i] <= '0;
                bits_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        if (cfg_index == CFG_GAIN) gain_reg <= cfg_data[15:0];
                        else if (cfg_index == CFG_BULL) bull_reg <= cfg_data;
                        else if (cfg_index == CFG_BEAR) bear_reg <= cfg_data;
                    end
                    if (s_valid) begin
                        in_reg <= s_data;
                        sel_reg <= 1'b0;
                    end
                end
                ST_MUL0: begin
                    plo_reg <= mul_p;
                end
                ST_MUL1: begin
                    nxt_reg <= ema_new;
                end
                ST_UPD: ;
                ST_SWING: begin
                    if (seen_reg == 2'd0) begin
                        now_reg[sel_reg] <= price_q16;
                    end else begin
                        if (seen_reg >= 2'd2 &&
                            (sel_reg ? (cur < back_reg[sel_reg] && cur < nxt_reg)
                                     : (cur > back_reg[sel_reg] && cur > nxt_reg))) begin
                            if (sw_reg[sel_reg] != 32'd0) begin
                                bits_reg[sel_reg] <= {bits_reg[sel_reg][WINDOW_MAX-2:0],
                                                      cur > lsw_reg[sel_reg]};
                                if (cur > lsw_reg[sel_reg] && ri_reg[sel_reg] != '1)
                                    ri_reg[sel_reg] <= ri_reg[sel_reg] + 32'd1;
                            end
                            lsw_reg[sel_reg] <= cur;
                            if (sw_reg[sel_reg] != '1)
                                sw_reg[sel_reg] <= sw_reg[sel_reg] + 32'd1;
                        end
                        back_reg[sel_reg] <= cur;
                        now_reg[sel_reg] <= nxt_reg;
                    end
                    if (sel_reg) begin
                        if (seen_reg != 2'd3) seen_reg <= seen_reg + 2'd1;
                        sel_reg <= in_reg.last_candle ? 1'b0 : 1'b1;
                    end else begin
                        sel_reg <= 1'b1;
                    end
                end
                ST_PREP: begin
                    pi_reg <= '0;
                    if (win_c == '0) begin
                        comps_reg <= sw_m1;
                        up_reg <= (ri_reg[sel_reg] > sw_m1) ? sw_m1 : ri_reg[sel_reg];
                    end else begin
                        comps_reg <= comps_c;
                        up_reg <= 32'd0;
                    end
                end
                ST_POP: begin
                    if (32'(pi_reg) < comps_reg && bits_reg[sel_reg][pi_reg[IB-1:0]])
                        up_reg <= up_reg + 32'd1;
                    pi_reg <= pi_reg + (IB+1)'(1);
                end
                ST_DSTRT: ;
                ST_DWAIT: begin
                    if (div_done) begin
                        f_reg[sel_reg] <= (comps_reg == 32'd0) ? HALF_Q16 : div_q;
                        sel_reg <= ~sel_reg;
                    end
                end
                ST_FIN: begin
                    out_reg.trend_score_q16 <= score;
                    if (score >= bull_reg) out_reg.trend_class <= CLS_BULL;
                    else if (score <= bear_reg) out_reg.trend_class <= CLS_BEAR;
                    else out_reg.trend_class <= CLS_UNSTABLE;
                    out_reg.high_swing_count <= sw_reg[0];
                    out_reg.low_swing_count <= sw_reg[1];
                    seen_reg <= 2'd0;
                    sel_reg <= 1'b0;
                    for (int i = 0; i < 2; i++) begin
                        now_reg[i] <= '0;
                        back_reg[i] <= '0;
                        lsw_reg[i] <= '0;
                        sw_reg[i] <= '0;
                        ri_reg[i] <= '0;
                        bits_reg[i] <= '0;
                    end
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // diff and sign latched ahead of the first partial product
    assign d_cur = (state_reg == ST_IDLE) ? now_reg[0] : now_reg[1];
    assign d_price = (state_reg == ST_IDLE) ? {8'd0, s_data.high_price, 8'd0}
                                            : {8'd0, in_reg.low_price, 8'd0};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE || state_reg == ST_SWING) begin
            neg_reg <= (d_price < d_cur);
            diff_reg <= (d_price >= d_cur) ? d_price - d_cur : d_cur - d_price;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.trend_class == CLS_BULL || m_data.trend_class == CLS_BEAR ||
                     m_data.trend_class == CLS_UNSTABLE))
        else $error("bad class code");
endmodule
